// File: design/ptp_pkg.sv
// shared constants, types and helpers of the pes to transport packetizer
// no dependencies; imported by every module and interface of the block but ptp_ram
package ptp_pkg;

    localparam int STREAMS_PER_PROGRAM = 8;
    localparam int PROGRAM_COUNT       = 8;
    localparam int LENGTH_BITS         = 20;

    // field widths of the channels
    localparam int LEN_W  = 20;
    localparam int PTS_W  = 33;
    localparam int IDX_W  = 3;
    localparam int BYTE_W = 8;
    localparam int PID_W  = 13;
    localparam int CC_W   = 4;

    // continuity counter store
    localparam int CC_SLOTS  = 64;
    localparam int SLOT_W    = $clog2(CC_SLOTS);

    localparam logic [LEN_W-1:0] LEN_MASK = LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

    localparam logic [BYTE_W-1:0] TS_SYNC       = 8'h47;
    localparam logic [PID_W-1:0]  PID_BASE      = 13'h0100;
    localparam logic [BYTE_W-1:0] FIRST_PAYLOAD = 8'd176;
    localparam logic [BYTE_W-1:0] LATER_PAYLOAD = 8'd182;
    localparam logic [BYTE_W-1:0] PACKET_SIZE   = 8'd188;
    localparam logic [BYTE_W-1:0] ADAPT_BASE    = 8'd183;
    localparam logic [BYTE_W-1:0] PCR_EXT_LOW   = 8'h7e;
    localparam logic [BYTE_W-1:0] STUFF_BYTE    = 8'hff;
    localparam logic [BYTE_W-1:0] CC_HIGH       = 8'h30;
    localparam logic [BYTE_W-1:0] PUSI_BIT      = 8'h40;
    localparam logic [BYTE_W-1:0] PCR_PRESENT   = 8'h10;

    // action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // byte positions inside a packet header
    localparam logic [BYTE_W-1:0] POS_SYNC   = 8'd0;
    localparam logic [BYTE_W-1:0] POS_PID_HI = 8'd1;
    localparam logic [BYTE_W-1:0] POS_PID_LO = 8'd2;
    localparam logic [BYTE_W-1:0] POS_CC     = 8'd3;
    localparam logic [BYTE_W-1:0] POS_ALEN   = 8'd4;
    localparam logic [BYTE_W-1:0] POS_FLAGS  = 8'd5;
    localparam logic [BYTE_W-1:0] POS_PCR0   = 8'd6;
    localparam logic [BYTE_W-1:0] POS_PCR1   = 8'd7;
    localparam logic [BYTE_W-1:0] POS_PCR2   = 8'd8;
    localparam logic [BYTE_W-1:0] POS_PCR3   = 8'd9;
    localparam logic [BYTE_W-1:0] POS_PCR4   = 8'd10;
    localparam logic [BYTE_W-1:0] POS_PCR5   = 8'd11;
    localparam logic [BYTE_W-1:0] POS_LAST   = 8'd187;

    // frame state handed to the byte formatter
    typedef struct packed {
        logic [BYTE_W-1:0] byte_in_packet;
        logic [BYTE_W-1:0] payload;
        logic              first_pkt;
        logic [PID_W-1:0]  pid;
        logic [PTS_W-1:0]  pcr;
        logic [LEN_W-1:0]  bytes_left;
        logic [CC_W-1:0]   cc;
    } t_frame_state;

    // formatter answer: output byte, flags and next frame state
    typedef struct packed {
        logic [BYTE_W-1:0] ts_byte;
        logic              took;
        logic              first;
        logic              last;
        logic              cc_bump;
        logic [BYTE_W-1:0] byte_in_packet;
        logic [BYTE_W-1:0] payload;
        logic              first_pkt;
        logic [LEN_W-1:0]  bytes_left;
        logic              frame_active;
    } t_fmt_res;

endpackage

// File: design/ptp_if.sv
// valid/ready channel interfaces of the pes to transport packetizer
// depends on ptp_pkg for the field widths
interface ptp_in_if import ptp_pkg::*;;
    logic              valid;
    logic              ready;
    logic              action;
    logic [LEN_W-1:0]  pes_length;
    logic [PTS_W-1:0]  pts;
    logic [IDX_W-1:0]  program_index;
    logic [IDX_W-1:0]  stream_index;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, action, pes_length, pts, program_index, stream_index,
                    data_byte, input ready);
    modport sink   (input valid, action, pes_length, pts, program_index, stream_index,
                    data_byte, output ready);
endinterface

interface ptp_out_if import ptp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] ts_byte;
    logic              took_byte;
    logic              packet_first;
    logic              frame_last;

    modport source (output valid, ts_byte, took_byte, packet_first, frame_last,
                    input ready);
    modport sink   (input valid, ts_byte, took_byte, packet_first, frame_last,
                    output ready);
endinterface

// File: design/ptp_ram.sv
// generic single write port ram with registered read
// no dependencies
module ptp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/ptp_cc.sv
// continuity counter store: one 4-bit counter per stream slot
// depends on ptp_pkg and ptp_ram; valid bits stand in for the reset value
module ptp_cc import ptp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_bump,
    output logic [CC_W-1:0]   o_cc
);
    logic [CC_SLOTS-1:0] r_valid;
    logic                r_vld_rd;
    logic [CC_W-1:0]     ram_rdata;

    ptp_ram #(.WIDTH(CC_W), .DEPTH(CC_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_bump),
        .i_waddr (i_slot),
        .i_wdata (o_cc + CC_W'(1)),
        .i_raddr (i_slot),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_vld_rd <= 1'b0;
        end else begin
            r_vld_rd <= r_valid[i_slot];
            if (i_bump) begin
                r_valid[i_slot] <= 1'b1;
            end
        end
    end

    // a slot never written reads as zero
    assign o_cc = r_vld_rd ? ram_rdata : '0;
endmodule

// File: design/ptp_fmt.sv
// byte formatter: picks the transport byte for the current packet position
// depends on ptp_pkg; purely combinational
module ptp_fmt import ptp_pkg::*; (
    input  t_frame_state      i_st,
    input  logic [BYTE_W-1:0] i_data_byte,
    output t_fmt_res          o_res
);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] limit;
    logic [BYTE_W-1:0] pay;
    logic [LEN_W-1:0]  bl_next;

    always_comb begin
        b     = i_st.byte_in_packet;
        limit = i_st.first_pkt ? FIRST_PAYLOAD : LATER_PAYLOAD;
        // payload size is fixed at the sync byte
        if (b == POS_SYNC) begin
            pay = (i_st.bytes_left < LEN_W'(limit)) ? i_st.bytes_left[BYTE_W-1:0] : limit;
        end else begin
            pay = i_st.payload;
        end

        o_res         = '0;
        o_res.payload = pay;

        if (b == POS_SYNC) begin
            o_res.ts_byte = TS_SYNC;
            o_res.first   = 1'b1;
        end else if (b == POS_PID_HI) begin
            o_res.ts_byte = (i_st.first_pkt ? PUSI_BIT : '0) |
                            {3'b000, i_st.pid[PID_W-1:8]};
        end else if (b == POS_PID_LO) begin
            o_res.ts_byte = i_st.pid[7:0];
        end else if (b == POS_CC) begin
            o_res.ts_byte = CC_HIGH | {4'b0000, i_st.cc};
            o_res.cc_bump = 1'b1;
        end else if (b == POS_ALEN) begin
            o_res.ts_byte = ADAPT_BASE - pay;
        end else if (b == POS_FLAGS) begin
            o_res.ts_byte = i_st.first_pkt ? PCR_PRESENT : '0;
        end else if (i_st.first_pkt && b == POS_PCR0) begin
            o_res.ts_byte = i_st.pcr[32:25];
        end else if (i_st.first_pkt && b == POS_PCR1) begin
            o_res.ts_byte = i_st.pcr[24:17];
        end else if (i_st.first_pkt && b == POS_PCR2) begin
            o_res.ts_byte = i_st.pcr[16:9];
        end else if (i_st.first_pkt && b == POS_PCR3) begin
            o_res.ts_byte = i_st.pcr[8:1];
        end else if (i_st.first_pkt && b == POS_PCR4) begin
            o_res.ts_byte = {i_st.pcr[0], 7'b0} | PCR_EXT_LOW;
        end else if (i_st.first_pkt && b == POS_PCR5) begin
            o_res.ts_byte = '0;
        end else if (b < PACKET_SIZE - pay) begin
            o_res.ts_byte = STUFF_BYTE;
        end else begin
            o_res.ts_byte = i_data_byte;
            o_res.took    = 1'b1;
        end

        bl_next = (o_res.took && i_st.bytes_left != '0) ?
                  i_st.bytes_left - LEN_W'(1) : i_st.bytes_left;
        o_res.bytes_left = bl_next;

        if (b >= POS_LAST) begin
            o_res.byte_in_packet = '0;
            o_res.first_pkt      = 1'b0;
            o_res.last           = (bl_next == '0);
            o_res.frame_active   = (bl_next != '0);
        end else begin
            o_res.byte_in_packet = b + BYTE_W'(1);
            o_res.first_pkt      = i_st.first_pkt;
            o_res.frame_active   = 1'b1;
        end
    end
endmodule

// File: design/pes_to_transport_packetizer.sv
// top level of the pes to transport packetizer
// depends on ptp_pkg, ptp_if, ptp_ram, ptp_cc and ptp_fmt

// A start beat (action 0) latches the frame length, the pts that becomes the
// pcr base and the pid/continuity slot of program and stream; it produces no
// output beat. Each step beat (action 1) while a frame is active produces
// exactly one transport byte; the offered data byte is consumed only when
// took_byte is 1, otherwise the source offers it again. Packets are 188 bytes:
// a 4-byte header, an adaptation field stuffed with 0xff (the first packet of
// a frame also carries pusi and a pcr) and up to 176 (first) or 182 payload
// bytes. One beat is taken per clock while the output is not stalled: the
// frame state and the output register are both written as the beat is
// accepted. A new beat, start or step, is taken whenever the output register
// is empty or drains in the same cycle, so a stalled output byte holds the
// input. Step beats with no active frame are dropped. The 64 per-stream
// continuity counters live in a small ram with a registered read from the
// latched slot; per-slot valid bits make them read as zero after reset, so no
// clearing pass is needed.
module pes_to_transport_packetizer import ptp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ptp_in_if.sink   i_in,
    ptp_out_if.source o_out
);
    // frame state
    logic              r_active;
    logic [BYTE_W-1:0] r_byte_in_packet;
    logic [BYTE_W-1:0] r_payload;
    logic              r_first_pkt;
    logic [LEN_W-1:0]  r_bytes_left;
    logic [PID_W-1:0]  r_pid;
    logic [PTS_W-1:0]  r_pcr;
    logic [SLOT_W-1:0] r_slot;

    // output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_ts_byte;
    logic              r_took;
    logic              r_first;
    logic              r_last;

    logic              acc;
    logic              acc_start;
    logic              acc_step;
    logic [LEN_W-1:0]  start_len;
    logic [PID_W-1:0]  start_slot;
    logic [CC_W-1:0]   cc;
    t_frame_state      st;
    t_fmt_res          fmt;

    // output register empties or drains this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign acc        = i_in.valid && i_in.ready;
    assign acc_start  = acc && (i_in.action == ACT_START);
    assign acc_step   = acc && (i_in.action == ACT_STEP) && r_active;

    assign start_len  = i_in.pes_length & LEN_MASK;
    assign start_slot = PID_W'(i_in.program_index) * PID_W'(STREAMS_PER_PROGRAM)
                      + PID_W'(i_in.stream_index);

    ptp_cc u_cc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (r_slot),
        .i_bump  (acc_step && fmt.cc_bump),
        .o_cc    (cc)
    );

    always_comb begin
        st.byte_in_packet = r_byte_in_packet;
        st.payload        = r_payload;
        st.first_pkt      = r_first_pkt;
        st.pid            = r_pid;
        st.pcr            = r_pcr;
        st.bytes_left     = r_bytes_left;
        st.cc             = cc;
    end

    ptp_fmt u_fmt (
        .i_st        (st),
        .i_data_byte (i_in.data_byte),
        .o_res       (fmt)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active         <= 1'b0;
            r_byte_in_packet <= '0;
            r_payload        <= '0;
            r_first_pkt      <= 1'b0;
            r_bytes_left     <= '0;
            r_pid            <= '0;
            r_slot           <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (acc_start) begin
                r_active         <= (start_len != '0);
                r_byte_in_packet <= '0;
                r_payload        <= '0;
                r_first_pkt      <= 1'b1;
                r_bytes_left     <= start_len;
                r_pid            <= PID_BASE + start_slot;
                r_slot           <= start_slot[SLOT_W-1:0];
            end else if (acc_step) begin
                r_active         <= fmt.frame_active;
                r_byte_in_packet <= fmt.byte_in_packet;
                r_payload        <= fmt.payload;
                r_first_pkt      <= fmt.first_pkt;
                r_bytes_left     <= fmt.bytes_left;
            end

            if (acc_step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcr <= '0;
        end else if (acc_start) begin
            r_pcr <= i_in.pts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_step) begin
            r_ts_byte <= fmt.ts_byte;
            r_took    <= fmt.took;
            r_first   <= fmt.first;
            r_last    <= fmt.last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.ts_byte      = r_ts_byte;
    assign o_out.took_byte    = r_took;
    assign o_out.packet_first = r_first;
    assign o_out.frame_last   = r_last;

    // packet position never runs past the packet
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_in_packet < PACKET_SIZE)
        else $error("packet position out of range");

    // a packet start beat is always the sync byte and never payload
    a_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_first) |-> (r_ts_byte == TS_SYNC && !r_took))
        else $error("packet start beat is not a bare sync byte");

    // the last byte of a frame closes the frame
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_step && fmt.last) |=> !r_active)
        else $error("frame still active after its last byte");

    // a full output register that is not drained keeps its beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_ts_byte)))
        else $error("stalled output beat changed");

    // payload is taken only after the header of the packet
    a_payload_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_step && fmt.took) |-> (r_byte_in_packet > POS_FLAGS))
        else $error("payload taken inside packet header");
endmodule

// File: tb/ptp_packetizer_checker.sv
// checker of the pes to transport packetizer: mirrors the packet formatter and
// compares every transport beat; depends on ptp_pkg and the ptp_if channels
module ptp_packetizer_checker import ptp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ptp_in_if    i_in_ch,
    ptp_out_if   i_out_ch,
    output int   o_error_count,
    output int   o_pending,
    output int   o_ts_bytes,
    output int   o_packets,
    output int   o_frames
);

    typedef struct packed {
        logic [BYTE_W-1:0] ts_byte;
        logic              took;
        logic              first;
        logic              last;
    } t_ts_beat;

    t_ts_beat expected_bytes[$];

    // mirrored frame state
    logic [CC_W-1:0]   cc_table [CC_SLOTS];
    logic [LEN_W-1:0]  remaining_q;
    logic [BYTE_W-1:0] pos_q;
    logic [BYTE_W-1:0] payload_q;
    logic              first_pkt_q;
    logic [PID_W-1:0]  pid_q;
    logic [PTS_W-1:0]  pcr_q;
    logic [SLOT_W-1:0] slot_q;
    logic              in_frame_q;

    int error_count, pending_count, ts_seen_count, packet_count, frame_count;

    assign o_error_count = error_count;
    assign o_pending     = pending_count;
    assign o_ts_bytes    = ts_seen_count;
    assign o_packets     = packet_count;
    assign o_frames      = frame_count;

    task automatic open_frame(input logic [LEN_W-1:0] len, input logic [IDX_W-1:0] prog,
                              input logic [IDX_W-1:0] strm, input logic [PTS_W-1:0] pts);
        int slot;
        slot        = int'(prog) * STREAMS_PER_PROGRAM + int'(strm);
        pid_q       = PID_W'(int'(PID_BASE) + slot);
        slot_q      = SLOT_W'(slot);
        pcr_q       = pts;
        remaining_q = len & LEN_MASK;
        pos_q       = '0;
        payload_q   = '0;
        first_pkt_q = 1'b1;
        in_frame_q  = ((len & LEN_MASK) != '0);
    endtask

    // one output step: the transport byte at the current packet position
    task automatic format_step(input logic [BYTE_W-1:0] data, output logic has_byte,
                               output t_ts_beat res);
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] lim;
        int                sh;
        b        = pos_q;
        res      = '0;
        has_byte = in_frame_q;
        if (!in_frame_q) return;
        if (b == POS_SYNC) begin
            lim       = first_pkt_q ? FIRST_PAYLOAD : LATER_PAYLOAD;
            payload_q = (remaining_q < LEN_W'(lim)) ? remaining_q[BYTE_W-1:0] : lim;
        end
        res.first = (b == POS_SYNC);
        if (b == POS_SYNC) begin
            res.ts_byte = TS_SYNC;
        end else if (b == POS_PID_HI) begin
            res.ts_byte = (first_pkt_q ? PUSI_BIT : 8'h00) | {3'b000, pid_q[12:8]};
        end else if (b == POS_PID_LO) begin
            res.ts_byte = pid_q[7:0];
        end else if (b == POS_CC) begin
            res.ts_byte      = CC_HIGH | {4'h0, cc_table[slot_q]};
            cc_table[slot_q] = cc_table[slot_q] + CC_W'(1);
        end else if (b == POS_ALEN) begin
            res.ts_byte = ADAPT_BASE - payload_q;
        end else if (b == POS_FLAGS) begin
            res.ts_byte = first_pkt_q ? PCR_PRESENT : 8'h00;
        end else if (first_pkt_q && b <= POS_PCR3) begin
            sh          = 25 - 8 * (int'(b) - int'(POS_PCR0));
            res.ts_byte = BYTE_W'(pcr_q >> sh);
        end else if (first_pkt_q && b == POS_PCR4) begin
            res.ts_byte = PCR_EXT_LOW | {pcr_q[0], 7'h00};
        end else if (first_pkt_q && b == POS_PCR5) begin
            res.ts_byte = 8'h00;
        end else if (int'(b) < int'(PACKET_SIZE) - int'(payload_q)) begin
            res.ts_byte = STUFF_BYTE;
        end else begin
            res.ts_byte = data;
            res.took    = 1'b1;
            if (remaining_q != '0) remaining_q = remaining_q - LEN_W'(1);
        end
        if (b == POS_LAST) begin
            pos_q       = '0;
            first_pkt_q = 1'b0;
            if (remaining_q == '0) begin
                res.last   = 1'b1;
                in_frame_q = 1'b0;
            end
        end else begin
            pos_q = b + BYTE_W'(1);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_ts_beat want, got, next_byte;
        logic     has;
        if (!i_rst_n) begin
            for (int i = 0; i < CC_SLOTS; i++) cc_table[i] = '0;
            remaining_q   = '0;
            pos_q         = '0;
            payload_q     = '0;
            first_pkt_q   = 1'b0;
            pid_q         = '0;
            pcr_q         = '0;
            slot_q        = '0;
            in_frame_q    = 1'b0;
            expected_bytes.delete();
            error_count   = 0;
            pending_count = 0;
            ts_seen_count = 0;
            packet_count  = 0;
            frame_count   = 0;
        end else begin
            if (i_out_ch.valid && i_out_ch.ready) begin
                got = '{ts_byte: i_out_ch.ts_byte, took: i_out_ch.took_byte,
                        first: i_out_ch.packet_first, last: i_out_ch.frame_last};
                ts_seen_count++;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected transport byte %02h", got.ts_byte);
                    error_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    pending_count--;
                    if (want.first) packet_count++;
                    if (want.last) frame_count++;
                    if (got.ts_byte !== want.ts_byte) begin
                        $error("ts_byte: expected %02h, got %02h", want.ts_byte, got.ts_byte);
                        error_count++;
                    end
                    if (got.took !== want.took) begin
                        $error("took_byte: expected %0b, got %0b", want.took, got.took);
                        error_count++;
                    end
                    if (got.first !== want.first) begin
                        $error("packet_first: expected %0b, got %0b", want.first, got.first);
                        error_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("frame_last: expected %0b, got %0b", want.last, got.last);
                        error_count++;
                    end
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                if (i_in_ch.action == ACT_START) begin
                    open_frame(i_in_ch.pes_length, i_in_ch.program_index,
                               i_in_ch.stream_index, i_in_ch.pts);
                end else begin
                    format_step(i_in_ch.data_byte, has, next_byte);
                    if (has) begin
                        expected_bytes.push_back(next_byte);
                        pending_count++;
                    end
                end
            end
        end
    end

endmodule

// File: tb/tb_pes_to_transport_packetizer.sv
// top of the packetizer testbench: clock, reset, beat stimulus and verdict
// depends on ptp_pkg, ptp_if, the packetizer rtl and ptp_packetizer_checker
module tb_pes_to_transport_packetizer;
    import ptp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ptp_in_if  in_ch();
    ptp_out_if out_ch();

    int error_count, pending, ts_bytes, packets, frames;

    // beats accepted so far, and what is left of the current sender burst
    int sent_beats = 0;
    int burst_left = 0;

    pes_to_transport_packetizer dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    ptp_packetizer_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_error_count(error_count),
        .o_pending    (pending),
        .o_ts_bytes   (ts_bytes),
        .o_packets    (packets),
        .o_frames     (frames)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // random 33-bit timestamp, top bit included
    function automatic logic [PTS_W-1:0] rand_pts();
        return PTS_W'({$urandom_range(0, 1), $urandom});
    endfunction

    // step beats needed to drain a whole frame: first packet holds 176, later ones 182
    function automatic int frame_beats(int len);
        int extra;
        if (len <= int'(FIRST_PAYLOAD)) return int'(PACKET_SIZE);
        extra = len - int'(FIRST_PAYLOAD);
        return int'(PACKET_SIZE) * (1 + (extra + int'(LATER_PAYLOAD) - 1) / int'(LATER_PAYLOAD));
    endfunction

    // one beat, held until the block takes it; bursts with random gaps in between
    task automatic send_beat(input logic act, input logic [LEN_W-1:0] len,
                             input logic [PTS_W-1:0] pts, input logic [IDX_W-1:0] prog,
                             input logic [IDX_W-1:0] strm, input logic [BYTE_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap        = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= act;
        in_ch.pes_length    <= len;
        in_ch.pts           <= pts;
        in_ch.program_index <= prog;
        in_ch.stream_index  <= strm;
        in_ch.data_byte     <= data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_beats++;
        burst_left--;
    endtask

    task automatic start_frame(input logic [LEN_W-1:0] len, input logic [IDX_W-1:0] prog,
                               input logic [IDX_W-1:0] strm);
        send_beat(ACT_START, len, rand_pts(), prog, strm, BYTE_W'($urandom));
    endtask

    // output steps; the fields a step ignores carry noise
    task automatic run_steps(input int n);
        repeat (n) send_beat(ACT_STEP, LEN_W'($urandom), rand_pts(), IDX_W'($urandom),
                             IDX_W'($urandom), BYTE_W'($urandom));
    endtask

    // mostly two hot slots so their continuity counters wrap, else any slot
    task automatic pick_stream(output logic [IDX_W-1:0] prog, output logic [IDX_W-1:0] strm);
        case ($urandom_range(0, 4))
            0, 1: begin
                prog = '0;
                strm = '0;
            end
            2: begin
                prog = '1;
                strm = '1;
            end
            default: begin
                prog = IDX_W'($urandom);
                strm = IDX_W'($urandom);
            end
        endcase
    endtask

    task automatic full_frame(input int len);
        logic [IDX_W-1:0] prog, strm;
        pick_stream(prog, strm);
        start_frame(LEN_W'(len), prog, strm);
        run_steps(frame_beats(len));
    endtask

    // receiver: stall pattern changes every span; one long hold-off fills the block
    initial begin : receiver
        int   mode, span;
        bit   held;
        logic rdy;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 96);
            repeat (span) begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = 1'($urandom_range(0, 1));
                    default: rdy = ($urandom_range(0, 7) == 0);
                endcase
                if (!held && sent_beats >= 300) begin
                    // long back-pressure while the sender keeps offering beats
                    held = 1'b1;
                    out_ch.ready <= 1'b0;
                    repeat (400) @(posedge i_clk);
                end
                out_ch.ready <= rdy;
                @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [IDX_W-1:0] prog, strm;
        int               pick, len;
        in_ch.valid         <= 1'b0;
        in_ch.action        <= ACT_START;
        in_ch.pes_length    <= '0;
        in_ch.pts           <= '0;
        in_ch.program_index <= '0;
        in_ch.stream_index  <= '0;
        in_ch.data_byte     <= '0;
        i_rst_n             <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero length leaves no frame, so the following step is dropped
        send_beat(ACT_START, '0, '1, '1, '1, 8'hff);
        send_beat(ACT_STEP, '1, '1, '1, '1, 8'h00);
        // highest slot, cut off before its counter byte
        send_beat(ACT_START, LEN_W'(1), '1, '1, '1, 8'h00);
        run_steps(3);
        // largest length, abandoned after the adaptation flags byte
        send_beat(ACT_START, LEN_MASK, '0, '0, '0, 8'hff);
        run_steps(6);
        // whole pcr base of a first packet with alternating bits
        send_beat(ACT_START, LEN_W'(FIRST_PAYLOAD), 33'h1_5555_5555, 3'd3, 3'd5, 8'h5a);
        run_steps(11);

        // payload boundaries, each frame run to its end
        full_frame(1);
        full_frame(int'(FIRST_PAYLOAD));
        full_frame(int'(FIRST_PAYLOAD) + 1);
        full_frame(int'(FIRST_PAYLOAD) + int'(LATER_PAYLOAD) + 1);

        while (sent_beats < 1600) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // frame abandoned by the next start, mostly inside the header
                pick_stream(prog, strm);
                len = ($urandom_range(0, 1) != 0) ? $urandom_range(1, int'(LEN_MASK))
                                                  : $urandom_range(1, 400);
                start_frame(LEN_W'(len), prog, strm);
                run_steps(($urandom_range(0, 4) != 0) ? $urandom_range(1, 14)
                                                      : $urandom_range(15, 400));
            end else if (pick < 80) begin
                full_frame(($urandom_range(0, 3) != 0) ? $urandom_range(1, 176)
                                                       : $urandom_range(177, 600));
            end else if (pick < 88) begin
                // trailing steps after the frame ended are dropped
                full_frame($urandom_range(1, 176));
                run_steps($urandom_range(1, 3));
            end else if (pick < 94) begin
                pick_stream(prog, strm);
                start_frame('0, prog, strm);
                run_steps($urandom_range(1, 2));
            end else begin
                send_beat(1'($urandom), LEN_W'($urandom), rand_pts(), IDX_W'($urandom),
                          IDX_W'($urandom), BYTE_W'($urandom));
            end
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        // stray bytes would show up within the output latency
        repeat (20) @(posedge i_clk);
        $display("summary: %0d input beats, %0d transport bytes, %0d packets, %0d frames ended",
                 sent_beats, ts_bytes, packets, frames);
        if (error_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
design/ptp_pkg.sv
design/ptp_if.sv
design/ptp_ram.sv
design/ptp_cc.sv
design/ptp_fmt.sv
design/pes_to_transport_packetizer.sv
tb/ptp_packetizer_checker.sv
tb/tb_pes_to_transport_packetizer.sv
